// File: hw/rtl/gbpl_pkg.sv
// Shared constants for the gain-bucket priority list.
package gbpl_pkg;

	localparam int MAX_CELLS = 1024;
	localparam int MAX_GAIN  = 64;
	localparam int NBUCKETS  = 2 * MAX_GAIN + 1;
	localparam int CELL_W    = $clog2(MAX_CELLS);
	localparam int PTR_W     = CELL_W + 1;
	localparam int BKT_W     = $clog2(NBUCKETS);
	localparam int LST_W     = $clog2(NBUCKETS + 1);

	localparam logic [PTR_W-1:0] NIL = PTR_W'(MAX_CELLS);

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_UPDATE = 2'd1;
	localparam logic [1:0] OP_POP    = 2'd2;
	localparam logic [1:0] OP_PEEK   = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_TOO_BIG = 2'd2;
	localparam logic [1:0] ST_SKIPPED = 2'd3;

	localparam logic REG_GAIN_OFFSET = 1'b0;
	localparam logic REG_SIDE_SELECT = 1'b1;

endpackage

// File: hw/rtl/gain_bucket_priority_list.sv
// Gain-bucket priority list: linked bucket lists in memories under one sequencer.
// Insert reads, checks and links; update also unlinks and reads the target bucket; peek and
// rejected items only read and check; pop also unlinks the tail and walks the max pointer
// past empty buckets. One item at a time; busy stays high until done, which the receiver
// cannot stall. Reset clears the bucket map at once, then a pass over all 1024 cells clears
// the per-cell listed marks while busy is high; configuration writes are taken throughout.
module gain_bucket_priority_list
	import gbpl_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic                wr_index,
	input  logic [6:0]          wr_data,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          op,
	input  logic [CELL_W-1:0]   cell_id,
	input  logic signed [7:0]   cell_gain,
	input  logic                cell_side,
	input  logic signed [2:0]   gain_change,
	input  logic                to_back,
	output logic                done,
	output logic [CELL_W-1:0]   best_cell,
	output logic [1:0]          status,
	output logic                is_empty
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLEAR = 4'd1;
	localparam logic [3:0] S_RD    = 4'd2;
	localparam logic [3:0] S_CHK   = 4'd3;
	localparam logic [3:0] S_PW    = 4'd4;
	localparam logic [3:0] S_UNL   = 4'd5;
	localparam logic [3:0] S_RDD   = 4'd6;
	localparam logic [3:0] S_LNK   = 4'd7;
	localparam logic [3:0] S_LNK2  = 4'd8;
	localparam logic [3:0] S_WALK  = 4'd9;

	logic [3:0]              state_q;
	logic [CELL_W:0]         clr_q;
	logic [6:0]              offset_q;
	logic                    side_q;
	logic [1:0]              op_q;
	logic [CELL_W-1:0]       c_q;
	logic [BKT_W-1:0]        b_q;
	logic signed [9:0]       src_q, dst_q;
	logic signed [2:0]       diff_q;
	logic                    back_q, cside_q;
	logic [PTR_W-1:0]        lnk_q;
	logic signed [8:0]       max_q, max_nx;
	logic [NBUCKETS-1:0]     ne_q;
	logic                    done_q, empty_q;
	logic [1:0]              status_q;
	logic [CELL_W-1:0]       best_q;

	// Memories: bucket head/tail pairs, per-cell links, per-cell listed mark.
	logic [2*PTR_W-1:0]      ht_mem [NBUCKETS];
	logic [PTR_W-1:0]        nxt_mem [MAX_CELLS];
	logic [PTR_W-1:0]        prv_mem [MAX_CELLS];
	logic [LST_W-1:0]        lst_mem [MAX_CELLS];
	logic [2*PTR_W-1:0]      ht_rd;
	logic [PTR_W-1:0]        nxt_rd, prv_rd;
	logic [LST_W-1:0]        lst_rd;

	logic                    ht_we, nxt_we, prv_we, lst_we;
	logic [2*PTR_W-1:0]      ht_wd;
	logic [CELL_W-1:0]       nxt_wa, prv_wa, lst_wa;
	logic [PTR_W-1:0]        nxt_wd, prv_wd;
	logic [LST_W-1:0]        lst_wd;

	logic signed [9:0]       src_c, dst_c;
	logic                    src_ok, dst_ok, diff_ok, mx_ok;
	logic [PTR_W-1:0]        hd, tl, cptr;
	logic                    p_ok, n_ok;
	logic [BKT_W-1:0]        src_b, src_m1;

	assign src_c  = 10'(cell_gain) + $signed({3'b000, offset_q});
	assign dst_c  = src_c + 10'(gain_change);
	assign src_ok = (src_q >= 0) && (src_q < 10'(NBUCKETS));
	assign dst_ok = (dst_q >= 0) && (dst_q < 10'(NBUCKETS));
	assign diff_ok = (diff_q <= 3'sd2) && (diff_q >= -3'sd2);
	assign mx_ok  = (max_q >= 0) && (max_q < 9'(NBUCKETS));
	assign src_b  = src_q[BKT_W-1:0];
	assign src_m1 = src_b - BKT_W'(1);

	// An empty bucket reads as null whatever its memory row holds.
	assign hd   = ne_q[b_q] ? ht_rd[2*PTR_W-1:PTR_W] : NIL;
	assign tl   = ne_q[b_q] ? ht_rd[PTR_W-1:0] : NIL;
	assign cptr = {1'b0, c_q};
	assign p_ok = !prv_rd[PTR_W-1];
	assign n_ok = !nxt_rd[PTR_W-1];

	always_comb begin
		ht_we  = 1'b0;
		ht_wd  = {hd, tl};
		nxt_we = 1'b0;
		nxt_wa = c_q;
		nxt_wd = NIL;
		prv_we = 1'b0;
		prv_wa = c_q;
		prv_wd = NIL;
		lst_we = 1'b0;
		lst_wa = c_q;
		lst_wd = '0;
		case (state_q)
			S_CLEAR: begin
				lst_we = 1'b1;
				lst_wa = clr_q[CELL_W-1:0];
			end
			S_UNL: begin
				ht_we  = 1'b1;
				ht_wd  = {p_ok ? hd : nxt_rd, n_ok ? tl : prv_rd};
				nxt_we = p_ok;
				nxt_wa = prv_rd[CELL_W-1:0];
				nxt_wd = nxt_rd;
				prv_we = n_ok;
				prv_wa = nxt_rd[CELL_W-1:0];
				prv_wd = prv_rd;
				lst_we = 1'b1;
			end
			S_LNK: begin
				ht_we  = 1'b1;
				nxt_we = 1'b1;
				prv_we = 1'b1;
				lst_we = 1'b1;
				lst_wd = LST_W'(b_q) + LST_W'(1);
				if (back_q) begin
					ht_wd  = {hd[PTR_W-1] ? cptr : hd, cptr};
					prv_wd = tl;
				end else begin
					ht_wd  = {cptr, tl[PTR_W-1] ? cptr : tl};
					nxt_wd = hd;
				end
			end
			S_LNK2: begin
				nxt_we = back_q && !lnk_q[PTR_W-1];
				nxt_wa = lnk_q[CELL_W-1:0];
				nxt_wd = cptr;
				prv_we = !back_q && !lnk_q[PTR_W-1];
				prv_wa = lnk_q[CELL_W-1:0];
				prv_wd = cptr;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ht_we)
			ht_mem[b_q] <= ht_wd;
		if (nxt_we)
			nxt_mem[nxt_wa] <= nxt_wd;
		if (prv_we)
			prv_mem[prv_wa] <= prv_wd;
		if (lst_we)
			lst_mem[lst_wa] <= lst_wd;
		ht_rd  <= ht_mem[b_q];
		nxt_rd <= nxt_mem[c_q];
		prv_rd <= prv_mem[c_q];
		lst_rd <= lst_mem[c_q];
	end

	// Max-pointer rule for insert and update, and one step of the walk after a pop.
	always_comb begin
		max_nx = max_q;
		if (state_q == S_LNK2) begin
			if (dst_q > 10'(max_q))
				max_nx = dst_q[8:0];
			else if (op_q == OP_UPDATE && !ne_q[src_b]) begin
				if (diff_q == -3'sd1)
					max_nx = dst_q[8:0];
				else if (diff_q == -3'sd2)
					max_nx = ne_q[src_m1] ? src_q[8:0] - 9'sd1 : dst_q[8:0];
			end
		end else if (state_q == S_WALK) begin
			if (!max_q[8] && !ne_q[max_q[BKT_W-1:0]])
				max_nx = max_q - 9'sd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			offset_q <= 7'(MAX_GAIN);
			side_q   <= 1'b0;
			max_q    <= '0;
			ne_q     <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			best_q   <= '0;
			empty_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			max_q  <= max_nx;
			if (wr_en) begin
				if (wr_index == REG_GAIN_OFFSET)
					offset_q <= wr_data;
				else
					side_q <= wr_data[0];
			end
			if (ht_we)
				ne_q[b_q] <= !ht_wd[2*PTR_W-1];
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q[CELL_W-1:0] == '1)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						op_q    <= op;
						c_q     <= cell_id;
						src_q   <= src_c;
						// An insert lands in its own bucket, so its target is the source.
						dst_q   <= (op == OP_INSERT) ? src_c : dst_c;
						diff_q  <= gain_change;
						cside_q <= cell_side;
						back_q  <= (op == OP_INSERT) || to_back;
						if (op == OP_POP || op == OP_PEEK)
							b_q <= (max_q >= 0 && max_q < 9'(NBUCKETS)) ?
								max_q[BKT_W-1:0] : '0;
						else
							b_q <= (src_c >= 0 && src_c < 10'(NBUCKETS)) ?
								src_c[BKT_W-1:0] : '0;
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					best_q   <= '0;
					status_q <= ST_OK;
					case (op_q)
						OP_INSERT: begin
							if (cside_q != side_q || !src_ok || lst_rd != '0) begin
								status_q <= ST_SKIPPED;
								done_q   <= 1'b1;
								empty_q  <= (max_q == -9'sd1);
								state_q  <= S_IDLE;
							end else
								state_q <= S_LNK;
						end
						OP_UPDATE: begin
							if (!diff_ok || !src_ok ||
								lst_rd != LST_W'(src_b) + LST_W'(1) || !dst_ok) begin
								status_q <= !diff_ok ? ST_TOO_BIG :
									(!src_ok || lst_rd != LST_W'(src_b) + LST_W'(1)) ?
									ST_SKIPPED : ST_TOO_BIG;
								done_q   <= 1'b1;
								empty_q  <= (max_q == -9'sd1);
								state_q  <= S_IDLE;
							end else
								state_q <= S_UNL;
						end
						default: begin
							if (!mx_ok || !ne_q[b_q]) begin
								status_q <= ST_EMPTY;
								done_q   <= 1'b1;
								empty_q  <= (max_q == -9'sd1);
								state_q  <= S_IDLE;
							end else begin
								best_q <= tl[CELL_W-1:0];
								if (op_q == OP_PEEK) begin
									done_q  <= 1'b1;
									empty_q <= (max_q == -9'sd1);
									state_q <= S_IDLE;
								end else begin
									c_q     <= tl[CELL_W-1:0];
									state_q <= S_PW;
								end
							end
						end
					endcase
				end
				S_PW: state_q <= S_UNL;
				S_UNL: begin
					if (op_q == OP_UPDATE) begin
						b_q     <= dst_q[BKT_W-1:0];
						state_q <= S_RDD;
					end else
						state_q <= S_WALK;
				end
				S_RDD: state_q <= S_LNK;
				S_LNK: begin
					lnk_q   <= back_q ? tl : hd;
					state_q <= S_LNK2;
				end
				S_LNK2: begin
					done_q  <= 1'b1;
					empty_q <= (max_nx == -9'sd1);
					state_q <= S_IDLE;
				end
				S_WALK: begin
					if (max_q[8] || ne_q[max_q[BKT_W-1:0]]) begin
						done_q  <= 1'b1;
						empty_q <= (max_q == -9'sd1);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign best_cell = best_q;
	assign status    = status_q;
	assign is_empty  = empty_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted item did not start work");
	a_empty_held: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> $stable(is_empty)) else $error("is_empty changed without a result");
	a_max_range: assert property (@(posedge clk) disable iff (!arst_n)
		(max_q >= -9'sd1) && (max_q < 9'(NBUCKETS)))
		else $error("max bucket pointer out of range");
`endif

endmodule

// File: test/gain_bucket_priority_list_test.sv
// Self-checking testbench for the gain-bucket priority list, with its own list predictor.
module gain_bucket_priority_list_test;
	import gbpl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 6000;

	typedef struct {
		logic [1:0]        op;
		logic [CELL_W-1:0] cid;
		logic signed [7:0] gain;
		logic              side;
		logic signed [2:0] chg;
		logic              back;
	} item_t;

	typedef struct {
		logic [CELL_W-1:0] best;
		logic [1:0]        st;
		logic              empty;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic wr_index = 1'b0;
	logic [6:0] wr_data = '0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] op = OP_PEEK;
	logic [CELL_W-1:0] cell_id = '0;
	logic signed [7:0] cell_gain = '0;
	logic cell_side = 1'b0;
	logic signed [2:0] gain_change = '0;
	logic to_back = 1'b0;
	logic done;
	logic [CELL_W-1:0] best_cell;
	logic [1:0] status;
	logic is_empty;

	gain_bucket_priority_list dut (.*);

	always #10 clk = ~clk;

	// Mirror of the bucket lists.
	int head_of[NBUCKETS];
	int tail_of[NBUCKETS];
	int next_of[MAX_CELLS];
	int prev_of[MAX_CELLS];
	int bucket_of[MAX_CELLS]; // 0 when not listed, else bucket + 1
	int top_bucket;
	int offset_reg;
	int side_reg;

	outcome_t pending_outcomes[$];
	int errors = 0;
	int idle_pct = 0;
	int stall_cycles = 0;

	function automatic void list_unlink(int c, int b);
		int p = prev_of[c];
		int n = next_of[c];
		if (p < MAX_CELLS) next_of[p] = n; else head_of[b] = n;
		if (n < MAX_CELLS) prev_of[n] = p; else tail_of[b] = p;
		bucket_of[c] = 0;
	endfunction

	function automatic void list_append(int c, int b);
		int t = tail_of[b];
		prev_of[c] = t;
		next_of[c] = MAX_CELLS;
		if (t < MAX_CELLS) next_of[t] = c; else head_of[b] = c;
		tail_of[b] = c;
		bucket_of[c] = b + 1;
	endfunction

	function automatic void list_prepend(int c, int b);
		int h = head_of[b];
		next_of[c] = h;
		prev_of[c] = MAX_CELLS;
		if (h < MAX_CELLS) prev_of[h] = c; else tail_of[b] = c;
		head_of[b] = c;
		bucket_of[c] = b + 1;
	endfunction

	function automatic bit bucket_clear(int b);
		return head_of[b] >= MAX_CELLS;
	endfunction

	function automatic outcome_t apply_item(item_t it);
		outcome_t o;
		int c = it.cid;
		int g = it.gain;
		int d = it.chg;
		int src = g + offset_reg;
		int dst = src + d;
		o.best = '0;
		o.st = ST_OK;
		if (it.op == OP_INSERT) begin
			if (it.side != side_reg || src < 0 || src >= NBUCKETS || bucket_of[c] != 0) begin
				o.st = ST_SKIPPED;
			end else begin
				list_append(c, src);
				if (src > top_bucket) top_bucket = src;
			end
		end else if (it.op == OP_UPDATE) begin
			if (d > 2 || d < -2) begin
				o.st = ST_TOO_BIG;
			end else if (src < 0 || src >= NBUCKETS || bucket_of[c] != src + 1) begin
				o.st = ST_SKIPPED;
			end else if (dst < 0 || dst >= NBUCKETS) begin
				o.st = ST_TOO_BIG;
			end else begin
				list_unlink(c, src);
				if (it.back) list_append(c, dst); else list_prepend(c, dst);
				// The pointer follows a fixed rule, even when the source was not the top.
				if (dst > top_bucket) begin
					top_bucket = dst;
				end else if (bucket_clear(src)) begin
					if (d == -1) top_bucket = dst;
					else if (d == -2) top_bucket = bucket_clear(src - 1) ? dst : src - 1;
				end
			end
		end else begin
			if (top_bucket < 0 || top_bucket >= NBUCKETS || bucket_clear(top_bucket)) begin
				o.st = ST_EMPTY;
			end else begin
				o.best = CELL_W'(tail_of[top_bucket]);
				if (it.op == OP_POP) begin
					list_unlink(o.best, top_bucket);
					while (top_bucket >= 0 && bucket_clear(top_bucket)) top_bucket--;
				end
			end
		end
		o.empty = (top_bucket == -1);
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch("results outstanding", 0, 1);
			end else begin
				outcome_t w;
				w = pending_outcomes.pop_front();
				if (best_cell !== w.best) report_mismatch("best_cell", best_cell, w.best);
				if (status !== w.st) report_mismatch("status", status, w.st);
				if (is_empty !== w.empty) report_mismatch("is_empty", is_empty, w.empty);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || wr_en) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("gain_bucket_priority_list_test: errors");
			$finish;
		end
	end

	// Called at a rising edge; returns after acceptance, start high unless it idled.
	task automatic send_item(item_t it);
		op <= it.op;
		cell_id <= it.cid;
		cell_gain <= it.gain;
		cell_side <= it.side;
		gain_change <= it.chg;
		to_back <= it.back;
		if (!start) start <= 1'b1;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		pending_outcomes.push_back(apply_item(it));
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [6:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_GAIN_OFFSET) offset_reg = val; else side_reg = val;
		@(posedge clk);
	endtask

	function automatic item_t mk(logic [1:0] o, int c, int g, logic s, int d, logic b);
		item_t it;
		it.op = o;
		it.cid = CELL_W'(c);
		it.gain = 8'(g);
		it.side = s;
		it.chg = 3'(d);
		it.back = b;
		return it;
	endfunction

	function automatic item_t random_item();
		item_t it;
		int pick = $urandom_range(99);
		int r = $urandom_range(99);
		int c;
		if (r < 5) c = $urandom_range(1023);
		else if (r < 8) c = 1023;
		else c = $urandom_range(47);
		it.cid = CELL_W'(c);
		it.back = 1'($urandom_range(1));
		it.side = ($urandom_range(99) < 85) ? side_reg[0] : ~side_reg[0];
		r = $urandom_range(99);
		if (r < 5) it.gain = 8'($urandom_range(255));
		else if (r < 55) it.gain = 8'($urandom_range(8) - 4);
		else it.gain = 8'($urandom_range(128) - offset_reg);
		it.chg = ($urandom_range(99) < 90) ? 3'($urandom_range(4) - 2) :
			($urandom_range(1) ? 3'sd3 : -3'sd3);
		if (pick < 35) begin
			it.op = OP_INSERT;
		end else if (pick < 70) begin
			it.op = OP_UPDATE;
			if (bucket_of[c] != 0 && $urandom_range(99) < 80)
				it.gain = 8'(bucket_of[c] - 1 - offset_reg);
		end else begin
			it.op = (pick < 85) ? OP_POP : OP_PEEK;
		end
		return it;
	endfunction

	task automatic test_directed();
		send_item(mk(OP_PEEK, 0, 0, 0, 0, 0));
		send_item(mk(OP_POP, 0, 0, 0, 0, 0));
		send_item(mk(OP_INSERT, 1023, 64, 0, 0, 0));
		send_item(mk(OP_INSERT, 0, -64, 0, 0, 0));
		send_item(mk(OP_INSERT, 5, 65, 0, 0, 0));
		send_item(mk(OP_INSERT, 5, -128, 0, 0, 0));
		send_item(mk(OP_INSERT, 1023, 64, 0, 0, 0));
		send_item(mk(OP_INSERT, 7, 3, 1, 0, 0));
		send_item(mk(OP_INSERT, 7, 3, 0, 0, 0));
		send_item(mk(OP_INSERT, 8, 3, 0, 0, 0));
		send_item(mk(OP_UPDATE, 7, 3, 0, 3, 1));
		send_item(mk(OP_UPDATE, 7, 3, 0, -3, 1));
		send_item(mk(OP_UPDATE, 9, 3, 0, 1, 1));
		send_item(mk(OP_UPDATE, 1023, 64, 0, 1, 1));
		send_item(mk(OP_UPDATE, 0, -64, 0, -2, 0));
		send_item(mk(OP_UPDATE, 7, 3, 0, 0, 0));
		send_item(mk(OP_UPDATE, 8, 3, 0, 0, 1));
		send_item(mk(OP_UPDATE, 7, 3, 0, -1, 0));
		send_item(mk(OP_UPDATE, 8, 3, 0, -2, 1));
		send_item(mk(OP_UPDATE, 1023, 64, 0, -2, 0));
		send_item(mk(OP_UPDATE, 0, -64, 0, 2, 1));
		send_item(mk(OP_PEEK, 0, 0, 0, 0, 0));
		repeat (6) send_item(mk(OP_POP, 0, 0, 0, 0, 0));
		wait_idle();
	endtask

	task automatic test_random(int count, int pct);
		idle_pct = pct;
		for (int i = 0; i < count; i++) begin
			send_item(random_item());
			// Once per phase, hold the next item until the block has caught up.
			if (i == count / 2) begin
				start <= 1'b0;
				while (pending_outcomes.size() != 0) @(posedge clk);
			end
		end
		wait_idle();
	endtask

	task automatic test_settings();
		write_reg(REG_GAIN_OFFSET, 7'd0);
		write_reg(REG_SIDE_SELECT, 7'd1);
		test_random(540, 52);
		write_reg(REG_GAIN_OFFSET, 7'd20);
		write_reg(REG_SIDE_SELECT, 7'd0);
		test_random(540, 0);
		write_reg(REG_GAIN_OFFSET, 7'd64);
		test_random(20, 0);
	endtask

	initial begin
		for (int i = 0; i < NBUCKETS; i++) begin
			head_of[i] = MAX_CELLS;
			tail_of[i] = MAX_CELLS;
		end
		for (int i = 0; i < MAX_CELLS; i++) begin
			next_of[i] = MAX_CELLS;
			prev_of[i] = MAX_CELLS;
			bucket_of[i] = 0;
		end
		top_bucket = 0;
		offset_reg = 64;
		side_reg = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(540, 16);
		test_settings();
		if (errors == 0) begin
			$display("gain_bucket_priority_list_test: clean");
		end else begin
			$display("gain_bucket_priority_list_test: errors");
		end
		$finish;
	end

endmodule
